### hdl/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int DEF_MAX_SETS = 4096;
  localparam int DEF_WAYS     = 4;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int KIND_W     = 2;
  localparam int WAY_OUT_W  = 3;
  localparam int OFFSET_W   = 3;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;
  localparam int SLOT_W     = 3;
  localparam int NUM_SLOTS  = 6;

  localparam logic [CNT_W-1:0] SAT_MAX = 32'hffffffff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE  = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 3'd3;
  localparam logic [INDEX_W-1:0]  INDEX_RESET  = 4'd11;
  localparam logic                SPLIT_RESET  = 1'b1;

  // access kinds
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic read_en;
    logic update_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } ctrl_status_t;

endpackage

### hdl/sacl_ctrl.sv
`timescale 1ns / 1ps

module sacl_ctrl import sacl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic [KIND_W-1:0] s_kind,
  output logic              s_tready,
  input  ctrl_status_t      status,
  output ctrl_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        // kind 3 is taken and dropped without touching the cache
        if (s_tvalid && (s_kind != KIND_UNUSED)) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!status.out_busy) begin
          cmd.update_en = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/sacl_datapath.sv
`timescale 1ns / 1ps

module sacl_datapath import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int WAYS     = DEF_WAYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status
);

  localparam int ROW_COUNT = 2 * MAX_SETS;
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int META_W    = WAYS + WAYS * RANK_W;
  localparam int TAGS_W    = WAYS * TAG_W;
  localparam int MAX_IB    = $clog2(MAX_SETS + 1) - 1;
  localparam int IB_W      = 5;
  localparam int SH_W      = 6;
  localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(WAYS - 1);

  // configuration
  logic [OFFSET_W-1:0] offset_bits;
  logic [INDEX_W-1:0]  index_bits;
  logic                split_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_RESET;
      index_bits  <= INDEX_RESET;
      split_mode  <= SPLIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OFFSET_W-1:0];
        CFG_INDEX_BITS:  index_bits  <= cfg_data[INDEX_W-1:0];
        CFG_SPLIT_MODE:  split_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // address split
  logic [IB_W-1:0]   ib_eff;
  logic [ADDR_W-1:0] set_val;
  logic [TAG_W-1:0]  tag_in;
  logic              bank_in;
  logic [ROW_W-1:0]  row_in;

  always_comb begin
    if ({1'b0, index_bits} > IB_W'(MAX_IB)) begin
      ib_eff = IB_W'(MAX_IB);
    end else begin
      ib_eff = {1'b0, index_bits};
    end
    set_val = (s_tdata >> offset_bits) & ~({ADDR_W{1'b1}} << ib_eff);
    tag_in  = s_tdata >> (SH_W'(offset_bits) + SH_W'(ib_eff));
    bank_in = split_mode && (s_tuser == KIND_FETCH);
    row_in  = (bank_in ? ROW_W'(MAX_SETS) : '0) + ROW_W'(set_val);
  end

  logic [KIND_W-1:0] kind_q;
  logic [TAG_W-1:0]  tag_q;
  logic [ROW_W-1:0]  row_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= s_tuser;
      tag_q  <= tag_in;
      row_q  <= row_in;
    end
  end

  // clearing sweep over all rows of both banks
  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clear_en && !status.clear_done) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  assign status.clear_done = (clr_row == ROW_W'(ROW_COUNT - 1));
  assign status.out_busy   = m_tvalid && !m_tready;

  // row memories: valid bits and ranks, and tags
  logic [META_W-1:0] meta_mem [ROW_COUNT];
  logic [TAGS_W-1:0] tag_mem  [ROW_COUNT];
  logic [META_W-1:0] rd_meta;
  logic [TAGS_W-1:0] rd_tags;
  logic [META_W-1:0] init_meta;
  logic [META_W-1:0] new_meta;
  logic [TAGS_W-1:0] new_tags;
  logic              meta_we;
  logic [ROW_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;

  assign meta_we    = cmd.clear_en || cmd.update_en;
  assign meta_waddr = cmd.clear_en ? clr_row : row_q;
  assign meta_wdata = cmd.clear_en ? init_meta : new_meta;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.read_en) begin
      rd_meta <= meta_mem[row_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      tag_mem[row_q] <= new_tags;
    end
    if (cmd.read_en) begin
      rd_tags <= tag_mem[row_q];
    end
  end

  // tag compare and lru update
  logic [RANK_W-1:0] rank      [WAYS];
  logic [RANK_W-1:0] rank_next [WAYS];
  logic [WAYS-1:0]   valid;
  logic              hit_any;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] hit_rank;
  logic [RANK_W-1:0] victim;

  always_comb begin
    init_meta = '0;
    valid     = rd_meta[WAYS-1:0];
    hit_any   = 1'b0;
    hit_way   = '0;
    victim    = '0;
    for (int w = 0; w < WAYS; w++) begin
      init_meta[WAYS + w*RANK_W +: RANK_W] = RANK_W'(w);
      rank[w] = rd_meta[WAYS + w*RANK_W +: RANK_W];
      if (!hit_any && valid[w] && (rd_tags[w*TAG_W +: TAG_W] == tag_q)) begin
        hit_any = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (rank[w] == '0) begin
        victim = RANK_W'(w);
      end
    end
    hit_rank = rank[hit_way];

    new_meta = rd_meta;
    new_tags = rd_tags;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_any) begin
        if (RANK_W'(w) == hit_way) begin
          rank_next[w] = TOP_RANK;
        end else if (rank[w] > hit_rank) begin
          rank_next[w] = rank[w] - 1'b1;
        end else begin
          rank_next[w] = rank[w];
        end
      end else begin
        if (rank[w] == '0) begin
          rank_next[w] = TOP_RANK;
          new_meta[w]  = 1'b1;
          new_tags[w*TAG_W +: TAG_W] = tag_q;
        end else begin
          rank_next[w] = rank[w] - 1'b1;
        end
      end
      new_meta[WAYS + w*RANK_W +: RANK_W] = rank_next[w];
    end
  end

  // saturating hit and miss counters, slot 2*kind for hits, 2*kind+1 for misses
  logic [CNT_W-1:0]  counters [NUM_SLOTS];
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_next;

  assign slot     = {kind_q, !hit_any};
  assign cnt_cur  = counters[slot];
  assign cnt_next = (cnt_cur == SAT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        counters[i] <= '0;
      end
    end else if (cmd.update_en) begin
      counters[slot] <= cnt_next;
    end
  end

  // output register
  logic                 out_hit;
  logic [WAY_OUT_W-1:0] out_way;
  logic [KIND_W-1:0]    out_kind;
  logic [CNT_W-1:0]     out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      out_hit   <= hit_any;
      out_way   <= WAY_OUT_W'(hit_any ? hit_way : victim);
      out_kind  <= kind_q;
      out_count <= cnt_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - CNT_W - WAY_OUT_W){1'b0}}, out_count, out_way};
  assign m_tuser = {out_kind, out_hit};

endmodule

### hdl/set_assoc_cache_lru_tag_check_core.sv
`timescale 1ns / 1ps
// each access is accepted, then its set's row is read, then the row is written back
// as the result is registered for output, in a single read-then-write pass over
// the set's row memory; the write-back waits while the last result is unaccepted
// reset: a clearing pass over all 2*MAX_SETS rows (8192 by default) sets every row
// invalid with rank equal to way number; no access is accepted until it ends

module set_assoc_cache_lru_tag_check_core import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int WAYS     = DEF_WAYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // address
  input  logic [KIND_W-1:0]     s_tuser,   // access_kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // way_used, event_count, zero fill
  output logic [OUT_USER_W-1:0] m_tuser,   // hit, kind_echo
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_kind   (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sacl_datapath #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
